// ----- sv/mpsp_pkg.sv -----
package mpsp_pkg;

  localparam int unsigned MAX_PAGES_DFLT = 8;
  localparam int unsigned MAX_RESULTS    = 8;
  localparam int unsigned NREP_W         = $clog2(MAX_RESULTS + 1);

  localparam int unsigned COORD_W = 12;
  localparam int unsigned DIM_W   = 13;
  localparam int unsigned PIDX_W  = 3;
  localparam int unsigned STEP_W  = 5;

  localparam logic [DIM_W-1:0] DIM_MAX    = 13'd4096;
  localparam logic [DIM_W-1:0] DIM_MIN    = 13'd2;
  localparam logic [DIM_W-1:0] PAGE_RESET = 13'd512;

  localparam logic REG_PAGE_WIDTH  = 1'b0;
  localparam logic REG_PAGE_HEIGHT = 1'b1;

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_RESET = 2'd1;
  localparam logic [1:0] ACT_FLUSH = 2'd2;

  localparam logic [2:0] ST_PLACED    = 3'd0;
  localparam logic [2:0] ST_NO_ROOM   = 3'd1;
  localparam logic [2:0] ST_TOO_LARGE = 3'd2;
  localparam logic [2:0] ST_DIRTY     = 3'd3;
  localparam logic [2:0] ST_CLEAN     = 3'd4;
  localparam logic [2:0] ST_RESET     = 3'd5;

  typedef logic [DIM_W-1:0]   dim_t;
  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [STEP_W-1:0]  step_t;

  typedef struct packed {
    logic [1:0] action;
    coord_t     sprite_width;
    coord_t     sprite_height;
  } req_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [PIDX_W-1:0] page_index;
    coord_t            place_x;
    coord_t            place_y;
    coord_t            dirty_x;
    coord_t            dirty_y;
    dim_t              dirty_w;
    dim_t              dirty_h;
    logic              last;
  } res_t;

  typedef struct packed {
    dim_t   cx;
    dim_t   cy;
    coord_t lh;
    logic   dirty;
    coord_t rx;
    coord_t ry;
    dim_t   rw;
    dim_t   rh;
  } page_ent_t;

  localparam page_ent_t ENT_RESET = '{
    cx: 13'd1, cy: 13'd1, lh: '0, dirty: 1'b1,
    rx: '0, ry: '0, rw: PAGE_RESET, rh: PAGE_RESET
  };

  typedef enum logic [2:0] {J_NEXT, J_GOTO, J_IF, J_IFN, J_DISPATCH} jmp_e;
  typedef enum logic [2:0] {C_BIG, C_PG_END, C_FIT, C_FULL, C_DIRTY, C_PEND, C_FL_END} cnd_e;
  typedef enum logic [1:0] {W_NONE, W_NEW, W_REWIND, W_CLEAN} wsel_e;
  typedef enum logic [1:0] {P_HOLD, P_CLR, P_INC} pgop_e;
  typedef enum logic [1:0] {E_NONE, E_ALWAYS, E_PEND} emit_e;
  typedef enum logic [1:0] {O_ZERO, O_PLACE, O_PEND} osel_e;

  typedef struct packed {
    jmp_e       jmp;
    cnd_e       cnd;
    step_t      tgt;
    logic       take;
    logic       rd;
    logic       calc1;
    logic       calc2;
    wsel_e      wsel;
    pgop_e      pg;
    logic       used_inc;
    logic       fl_init;
    logic       pend_ld;
    emit_e      emit;
    osel_e      osel;
    logic [2:0] st;
    logic       olast;
  } uword_t;

  localparam uword_t UW_NOP = '{
    jmp: J_NEXT, cnd: C_BIG, tgt: '0, take: 1'b0, rd: 1'b0, calc1: 1'b0,
    calc2: 1'b0, wsel: W_NONE, pg: P_HOLD, used_inc: 1'b0, fl_init: 1'b0,
    pend_ld: 1'b0, emit: E_NONE, osel: O_ZERO, st: ST_PLACED, olast: 1'b0
  };

  typedef struct packed {
    logic   go;
    uword_t uw;
  } ctl_t;

  typedef struct packed {
    logic       accept;
    logic [1:0] act;
    logic       big;
    logic       pg_end;
    logic       fit;
    logic       full;
    logic       dirty;
    logic       pend;
    logic       fl_end;
    logic       out_free;
  } stat_t;

endpackage

// ----- sv/mpsp_stream_if.sv -----
interface mpsp_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

// ----- sv/multi_page_shelf_packer.sv -----
// Shelf packer over up to MAX_PAGES atlas pages of one shared size.
// Requests enter on req_i (valid/ready): add a sprite, rewind all pages, or
// flush dirty rectangles. Results leave on res_o (valid/ready); last marks
// the final result of a request. page_width and page_height are written on
// the cfg port (index 0 and 1) while the block is idle; the user keeps to
// this, as the block does not enforce it. Values saturate to 2..4096.
// An add checks the sprite against the page size, then tries each page in use
// in turn (read, calculate, fit check); if none fits and a page is free, it
// opens a new page and tries that. Rewind rewrites each page in use as empty
// and wholly dirty; flush reports each dirty page and marks it clean.
// Pages are read and written through the single-port page memory, and a small
// microcode program steps the datapath through each; one request is in work
// at a time, and the next is taken the cycle after the last result loads.
// Reset gives 512x512 pages, one page in use with its cursor at (1,1), and
// that page wholly dirty. When the receiver stalls, the result waits in the
// output register and the program holds at the step that produces the next.
module multi_page_shelf_packer #(
  parameter int unsigned MAX_PAGES = mpsp_pkg::MAX_PAGES_DFLT
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_idx_i,
  input  mpsp_pkg::dim_t cfg_data_i,
  mpsp_stream_if.sink    req_i,
  mpsp_stream_if.source  res_o
);
  import mpsp_pkg::*;

  dim_t  pw_q, pw_d, ph_q, ph_d;
  dim_t  cfg_sat;
  ctl_t  ctl;
  stat_t stat;

  always_comb begin
    if (cfg_data_i > DIM_MAX) begin
      cfg_sat = DIM_MAX;
    end else if (cfg_data_i < DIM_MIN) begin
      cfg_sat = DIM_MIN;
    end else begin
      cfg_sat = cfg_data_i;
    end
  end

  always_comb begin
    pw_d = pw_q;
    ph_d = ph_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_PAGE_WIDTH:  pw_d = cfg_sat;
        REG_PAGE_HEIGHT: ph_d = cfg_sat;
        default:         pw_d = pw_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pw_q <= PAGE_RESET;
      ph_q <= PAGE_RESET;
    end else begin
      pw_q <= pw_d;
      ph_q <= ph_d;
    end
  end

  mpsp_sequencer u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  mpsp_datapath #(
    .MAX_PAGES (MAX_PAGES)
  ) u_dp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .pw_i   (pw_q),
    .ph_i   (ph_q),
    .ctl_i  (ctl),
    .stat_o (stat),
    .req_i  (req_i),
    .res_o  (res_o)
  );

endmodule

// ----- sv/mpsp_sequencer.sv -----
module mpsp_sequencer (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mpsp_pkg::stat_t stat_i,
  output mpsp_pkg::ctl_t  ctl_o
);
  import mpsp_pkg::*;

  localparam step_t S_IDLE    = 5'd0;
  localparam step_t S_ADD     = 5'd1;
  localparam step_t S_TRY     = 5'd2;
  localparam step_t S_CALC1   = 5'd3;
  localparam step_t S_CALC2   = 5'd4;
  localparam step_t S_CHECK   = 5'd5;
  localparam step_t S_PLACE   = 5'd6;
  localparam step_t S_NEXT    = 5'd7;
  localparam step_t S_NEW     = 5'd8;
  localparam step_t S_OPEN    = 5'd9;
  localparam step_t S_NRD     = 5'd10;
  localparam step_t S_NCALC1  = 5'd11;
  localparam step_t S_NCALC2  = 5'd12;
  localparam step_t S_NCHECK  = 5'd13;
  localparam step_t S_NOROOM  = 5'd14;
  localparam step_t S_BIG     = 5'd15;
  localparam step_t S_RST     = 5'd16;
  localparam step_t S_RLOOP   = 5'd17;
  localparam step_t S_RWR     = 5'd18;
  localparam step_t S_RDONE   = 5'd19;
  localparam step_t S_FL      = 5'd20;
  localparam step_t S_FLOOP   = 5'd21;
  localparam step_t S_FCHK    = 5'd22;
  localparam step_t S_FREP    = 5'd23;
  localparam step_t S_FNEXT   = 5'd24;
  localparam step_t S_FEND    = 5'd25;
  localparam step_t S_FLAST   = 5'd26;
  localparam step_t S_FNONE   = 5'd27;

  function automatic uword_t rom(input step_t a);
    uword_t w;
    w = UW_NOP;
    unique case (a)
      S_IDLE: begin
        w.take = 1'b1; w.jmp = J_DISPATCH;
      end
      S_ADD: begin
        w.pg = P_CLR; w.jmp = J_IF; w.cnd = C_BIG; w.tgt = S_BIG;
      end
      S_TRY: begin
        w.rd = 1'b1; w.jmp = J_IF; w.cnd = C_PG_END; w.tgt = S_NEW;
      end
      S_CALC1:  w.calc1 = 1'b1;
      S_CALC2:  w.calc2 = 1'b1;
      S_CHECK: begin
        w.jmp = J_IFN; w.cnd = C_FIT; w.tgt = S_NEXT;
      end
      S_PLACE: begin
        w.wsel = W_NEW; w.emit = E_ALWAYS; w.osel = O_PLACE; w.st = ST_PLACED;
        w.olast = 1'b1; w.jmp = J_GOTO; w.tgt = S_IDLE;
      end
      S_NEXT: begin
        w.pg = P_INC; w.jmp = J_GOTO; w.tgt = S_TRY;
      end
      S_NEW: begin
        w.jmp = J_IF; w.cnd = C_FULL; w.tgt = S_NOROOM;
      end
      S_OPEN: begin
        w.wsel = W_REWIND; w.used_inc = 1'b1;
      end
      S_NRD:    w.rd = 1'b1;
      S_NCALC1: w.calc1 = 1'b1;
      S_NCALC2: w.calc2 = 1'b1;
      S_NCHECK: begin
        w.jmp = J_IF; w.cnd = C_FIT; w.tgt = S_PLACE;
      end
      S_NOROOM: begin
        w.emit = E_ALWAYS; w.st = ST_NO_ROOM; w.olast = 1'b1;
        w.jmp = J_GOTO; w.tgt = S_IDLE;
      end
      S_BIG: begin
        w.emit = E_ALWAYS; w.st = ST_TOO_LARGE; w.olast = 1'b1;
        w.jmp = J_GOTO; w.tgt = S_IDLE;
      end
      S_RST:    w.pg = P_CLR;
      S_RLOOP: begin
        w.jmp = J_IF; w.cnd = C_PG_END; w.tgt = S_RDONE;
      end
      S_RWR: begin
        w.wsel = W_REWIND; w.pg = P_INC; w.jmp = J_GOTO; w.tgt = S_RLOOP;
      end
      S_RDONE: begin
        w.emit = E_ALWAYS; w.st = ST_RESET; w.olast = 1'b1;
        w.jmp = J_GOTO; w.tgt = S_IDLE;
      end
      S_FL: begin
        w.pg = P_CLR; w.fl_init = 1'b1;
      end
      S_FLOOP: begin
        w.rd = 1'b1; w.jmp = J_IF; w.cnd = C_FL_END; w.tgt = S_FEND;
      end
      S_FCHK: begin
        w.jmp = J_IFN; w.cnd = C_DIRTY; w.tgt = S_FNEXT;
      end
      S_FREP: begin
        w.emit = E_PEND; w.osel = O_PEND; w.st = ST_DIRTY;
        w.pend_ld = 1'b1; w.wsel = W_CLEAN;
      end
      S_FNEXT: begin
        w.pg = P_INC; w.jmp = J_GOTO; w.tgt = S_FLOOP;
      end
      S_FEND: begin
        w.jmp = J_IFN; w.cnd = C_PEND; w.tgt = S_FNONE;
      end
      S_FLAST: begin
        w.emit = E_ALWAYS; w.osel = O_PEND; w.st = ST_DIRTY; w.olast = 1'b1;
        w.jmp = J_GOTO; w.tgt = S_IDLE;
      end
      S_FNONE: begin
        w.emit = E_ALWAYS; w.st = ST_CLEAN; w.olast = 1'b1;
        w.jmp = J_GOTO; w.tgt = S_IDLE;
      end
      default: begin
        w.jmp = J_GOTO; w.tgt = S_IDLE;
      end
    endcase
    return w;
  endfunction

  function automatic step_t dispatch(input logic [1:0] act);
    step_t s;
    unique case (act)
      ACT_ADD:   s = S_ADD;
      ACT_RESET: s = S_RST;
      ACT_FLUSH: s = S_FL;
      default:   s = S_IDLE;
    endcase
    return s;
  endfunction

  step_t  upc_q, upc_d;
  uword_t uw;
  logic   go;
  logic   cond;

  assign uw = rom(upc_q);

  always_comb begin
    unique case (uw.emit)
      E_ALWAYS: go = stat_i.out_free;
      E_PEND:   go = stat_i.out_free || !stat_i.pend;
      default:  go = 1'b1;
    endcase
  end

  always_comb begin
    unique case (uw.cnd)
      C_BIG:    cond = stat_i.big;
      C_PG_END: cond = stat_i.pg_end;
      C_FIT:    cond = stat_i.fit;
      C_FULL:   cond = stat_i.full;
      C_DIRTY:  cond = stat_i.dirty;
      C_PEND:   cond = stat_i.pend;
      C_FL_END: cond = stat_i.fl_end;
      default:  cond = 1'b0;
    endcase
  end

  always_comb begin
    upc_d = upc_q;
    if (go) begin
      unique case (uw.jmp)
        J_NEXT:     upc_d = upc_q + 5'd1;
        J_GOTO:     upc_d = uw.tgt;
        J_IF:       upc_d = cond ? uw.tgt : upc_q + 5'd1;
        J_IFN:      upc_d = cond ? upc_q + 5'd1 : uw.tgt;
        J_DISPATCH: upc_d = stat_i.accept ? dispatch(stat_i.act) : upc_q;
        default:    upc_d = S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= S_IDLE;
    end else begin
      upc_q <= upc_d;
    end
  end

  assign ctl_o.go = go;
  assign ctl_o.uw = uw;

endmodule

// ----- sv/mpsp_datapath.sv -----
module mpsp_datapath #(
  parameter int unsigned MAX_PAGES = mpsp_pkg::MAX_PAGES_DFLT
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mpsp_pkg::dim_t  pw_i,
  input  mpsp_pkg::dim_t  ph_i,
  input  mpsp_pkg::ctl_t  ctl_i,
  output mpsp_pkg::stat_t stat_o,
  mpsp_stream_if.sink     req_i,
  mpsp_stream_if.source   res_o
);
  import mpsp_pkg::*;

  localparam int unsigned CntW = $clog2(MAX_PAGES + 1);
  localparam int unsigned IdxW = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;

  logic accept;
  logic go;
  logic we;
  logic emit_now;
  logic out_free;

  coord_t     sw_q, sh_q;
  logic [CntW-1:0] pg_q, used_q;
  logic [NREP_W-1:0] nrep_q;
  logic       fresh_q;

  page_ent_t  mem_q [MAX_PAGES];
  page_ent_t  rd_q;
  logic       rd_fresh_q;
  page_ent_t  ent;
  page_ent_t  wdata;
  logic [IdxW-1:0] addr;

  dim_t        px_q;
  logic [13:0] py_q;
  coord_t      lh_q;
  logic        fit_q;
  dim_t        x0_q;
  logic [13:0] y0_q;
  logic [13:0] x1_q;
  logic [14:0] y1_q;

  logic [13:0] end_x, wrap_y, pxw, rxe;
  logic [14:0] end_y, rye;
  logic        wrap;

  logic              pend_valid_q;
  logic [PIDX_W-1:0] pend_pg_q;
  page_ent_t         pend_ent_q;

  logic out_valid_q;
  res_t out_q, out_d;

  assign go     = ctl_i.go;
  assign accept = req_i.valid && req_i.ready;
  assign addr   = pg_q[IdxW-1:0];
  assign ent    = rd_fresh_q ? ENT_RESET : rd_q;

  assign req_i.ready = ctl_i.uw.take;

  always_ff @(posedge clk_i) begin
    if (accept) begin
      sw_q <= req_i.payload.sprite_width;
      sh_q <= req_i.payload.sprite_height;
    end
  end

  always_comb begin
    unique case (ctl_i.uw.wsel)
      W_NEW: begin
        wdata.cx    = px_q + dim_t'(sw_q) + 13'd1;
        wdata.cy    = py_q[DIM_W-1:0];
        wdata.lh    = (lh_q < sh_q) ? sh_q : lh_q;
        wdata.dirty = 1'b1;
        wdata.rx    = x0_q[COORD_W-1:0];
        wdata.ry    = y0_q[COORD_W-1:0];
        wdata.rw    = dim_t'(x1_q - {1'b0, x0_q});
        wdata.rh    = dim_t'(y1_q - {1'b0, y0_q});
      end
      W_REWIND: begin
        wdata    = ENT_RESET;
        wdata.rw = pw_i;
        wdata.rh = ph_i;
      end
      W_CLEAN: begin
        wdata       = ent;
        wdata.dirty = 1'b0;
      end
      default: wdata = ent;
    endcase
  end

  assign we = go && (ctl_i.uw.wsel != W_NONE);

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[addr] <= wdata;
    end
    if (go && ctl_i.uw.rd && (pg_q != CntW'(MAX_PAGES))) begin
      rd_q       <= mem_q[addr];
      rd_fresh_q <= fresh_q && (pg_q == '0);
    end
  end

  assign end_x  = {1'b0, ent.cx} + {2'b0, sw_q} + 14'd1;
  assign wrap   = end_x > {1'b0, pw_i};
  assign wrap_y = {1'b0, ent.cy} + {2'b0, ent.lh} + 14'd1;

  assign end_y = {1'b0, py_q} + {3'b0, sh_q};
  assign pxw   = {1'b0, px_q} + {2'b0, sw_q};
  assign rxe   = {2'b0, ent.rx} + {1'b0, ent.rw};
  assign rye   = {3'b0, ent.ry} + {2'b0, ent.rh};

  always_ff @(posedge clk_i) begin
    if (go && ctl_i.uw.calc1) begin
      px_q <= wrap ? '0 : ent.cx;
      py_q <= wrap ? wrap_y : {1'b0, ent.cy};
      lh_q <= wrap ? '0 : ent.lh;
    end
    if (go && ctl_i.uw.calc2) begin
      fit_q <= end_y <= {2'b0, ph_i};
      x0_q  <= (ent.dirty && ({1'b0, ent.rx} < px_q)) ? {1'b0, ent.rx} : px_q;
      y0_q  <= (ent.dirty && ({2'b0, ent.ry} < py_q)) ? {2'b0, ent.ry} : py_q;
      x1_q  <= (ent.dirty && (rxe > pxw)) ? rxe : pxw;
      y1_q  <= (ent.dirty && (rye > end_y)) ? rye : end_y;
    end
    if (go && ctl_i.uw.pend_ld) begin
      pend_pg_q  <= PIDX_W'(pg_q);
      pend_ent_q <= ent;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pg_q         <= '0;
      used_q       <= CntW'(1);
      nrep_q       <= '0;
      fresh_q      <= 1'b1;
      pend_valid_q <= 1'b0;
    end else begin
      if (go) begin
        unique case (ctl_i.uw.pg)
          P_CLR:   pg_q <= '0;
          P_INC:   pg_q <= pg_q + CntW'(1);
          default: pg_q <= pg_q;
        endcase
        if (ctl_i.uw.used_inc) begin
          used_q <= used_q + CntW'(1);
        end
        if (ctl_i.uw.fl_init) begin
          nrep_q       <= '0;
          pend_valid_q <= 1'b0;
        end else if (ctl_i.uw.pend_ld) begin
          nrep_q       <= nrep_q + NREP_W'(1);
          pend_valid_q <= 1'b1;
        end
      end
      if (we && (pg_q == '0)) begin
        fresh_q <= 1'b0;
      end
    end
  end

  assign out_free = !out_valid_q || res_o.ready;
  assign emit_now = go && ((ctl_i.uw.emit == E_ALWAYS) ||
                           ((ctl_i.uw.emit == E_PEND) && pend_valid_q));

  always_comb begin
    out_d        = '0;
    out_d.status = ctl_i.uw.st;
    out_d.last   = ctl_i.uw.olast;
    unique case (ctl_i.uw.osel)
      O_PLACE: begin
        out_d.page_index = PIDX_W'(pg_q);
        out_d.place_x    = px_q[COORD_W-1:0];
        out_d.place_y    = py_q[COORD_W-1:0];
      end
      O_PEND: begin
        out_d.page_index = pend_pg_q;
        out_d.dirty_x    = pend_ent_q.rx;
        out_d.dirty_y    = pend_ent_q.ry;
        out_d.dirty_w    = pend_ent_q.rw;
        out_d.dirty_h    = pend_ent_q.rh;
      end
      default: out_d.page_index = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (emit_now) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit_now) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  assign res_o.valid   = out_valid_q;
  assign res_o.payload = out_q;

  assign stat_o.accept   = accept;
  assign stat_o.act      = req_i.payload.action;
  assign stat_o.big      = (dim_t'(sw_q) >= pw_i) || (dim_t'(sh_q) >= ph_i);
  assign stat_o.pg_end   = pg_q == used_q;
  assign stat_o.fit      = fit_q;
  assign stat_o.full     = used_q == CntW'(MAX_PAGES);
  assign stat_o.dirty    = ent.dirty;
  assign stat_o.pend     = pend_valid_q;
  assign stat_o.fl_end   = (pg_q == used_q) || (nrep_q == NREP_W'(MAX_RESULTS));
  assign stat_o.out_free = out_free;

endmodule
